### rtl/core/text_window_cursor_engine_assert.svh
// Assertion macros for the text window cursor engine.
// Each macro needs clk_i and rst_ni in the scope where it is used.
`ifndef TEXT_WINDOW_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_WINDOW_CURSOR_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define TWCE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`define TWCE_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`define TWCE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define TWCE_ASSERT(label, cond, msg)
`define TWCE_ASSERT_IMPL(label, pre, post, msg)
`define TWCE_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

### rtl/core/twce_pkg.sv
// Shared types and constants of the text window cursor engine.
// No dependencies; the step logic, result queue, top level and bench import it.
`default_nettype none

package twce_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [7:0] RESET_ROWS    = 8'd25;
  localparam logic [7:0] RESET_ATTR    = 8'd7;

  typedef enum logic {
    OP_PUT_CHAR = 1'b0,
    OP_SET_POS  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_ATTR    = 2'd2
  } reg_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic [7:0] pos_column;
    logic [7:0] pos_row;
  } twce_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [15:0] cell_word;
    logic        status;
    logic        last;
  } twce_out_t;

  // Results of one item, handed to the result queue together in a single push.
  typedef struct packed {
    logic [1:0] count;
    twce_out_t  first;
    twce_out_t  second;
  } twce_push_t;

endpackage

`default_nettype wire

### rtl/core/twce_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Used for both the item and the result channel of the cursor engine.
`default_nettype none

interface twce_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

### rtl/core/twce_step.sv
// Cursor step logic: next cursor and result words for one item.
// Depends on twce_pkg.
`default_nettype none

module twce_step #(
  parameter int COORD_BITS = 8
) (
  input  twce_pkg::twce_in_t     item_i,
  input  logic [COORD_BITS-1:0]  cur_col_i,
  input  logic [COORD_BITS-1:0]  cur_row_i,
  input  logic [7:0]             cols_i,
  input  logic [7:0]             rows_i,
  input  logic [7:0]             attr_i,
  output twce_pkg::twce_push_t   push_o,
  output logic [COORD_BITS-1:0]  nxt_col_o,
  output logic [COORD_BITS-1:0]  nxt_row_o
);
  import twce_pkg::*;

  localparam int CmpW = (COORD_BITS > 8) ? COORD_BITS : 8;

  logic [7:0]      last_col;
  logic [7:0]      last_row;
  logic [CmpW-1:0] x_ext;
  logic [CmpW-1:0] y_ext;
  logic [CmpW-1:0] lc_ext;
  logic [CmpW-1:0] lr_ext;
  logic [15:0]     word;

  // A zero size acts as one.
  assign last_col = (cols_i == 8'd0) ? 8'd0 : cols_i - 8'd1;
  assign last_row = (rows_i == 8'd0) ? 8'd0 : rows_i - 8'd1;
  assign x_ext    = CmpW'(cur_col_i);
  assign y_ext    = CmpW'(cur_row_i);
  assign lc_ext   = CmpW'(last_col);
  assign lr_ext   = CmpW'(last_row);
  assign word     = {attr_i, item_i.char_code};

  always_comb begin
    twce_out_t             wr;
    twce_out_t             sc;
    twce_out_t             st;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  bad;

    x   = cur_col_i;
    y   = cur_row_i;
    bad = (item_i.pos_column > last_col) || (item_i.pos_row > last_row);

    wr = '0;
    wr.kind = KIND_WRITE;
    wr.cell_word = word;
    sc = '0;
    sc.kind = KIND_SCROLL;
    st = '0;
    st.kind = KIND_STATUS;
    st.status = bad;
    st.last = 1'b1;

    push_o = '0;

    if (item_i.operation == OP_SET_POS) begin
      push_o.count = 2'd1;
      push_o.first = st;
      if (!bad) begin
        x = COORD_BITS'(item_i.pos_column);
        y = COORD_BITS'(item_i.pos_row);
      end
    end else begin
      priority if (item_i.char_code == CH_NUL) begin
        // end of string: drop
      end else if (item_i.char_code == CH_NEWLINE) begin
        if (y_ext == lr_ext) begin
          sc.last = 1'b1;
          push_o.count = 2'd1;
          push_o.first = sc;
        end else begin
          y = COORD_BITS'(cur_row_i + 1'b1);
        end
      end else if (item_i.char_code == CH_RETURN) begin
        x = '0;
      end else if (item_i.char_code == CH_BACKSPACE) begin
        if (cur_col_i != '0) begin
          x = COORD_BITS'(cur_col_i - 1'b1);
        end else if (cur_row_i != '0) begin
          y = COORD_BITS'(cur_row_i - 1'b1);
          x = COORD_BITS'(last_col);
        end
        wr.cell_column = 8'(x);
        wr.cell_row = 8'(y);
        wr.last = 1'b1;
        push_o.count = 2'd1;
        push_o.first = wr;
      end else begin
        wr.cell_column = 8'(cur_col_i);
        wr.cell_row = 8'(cur_row_i);
        push_o.first = wr;
        push_o.count = 2'd1;
        if (x_ext == lc_ext) begin
          if (y_ext == lr_ext) begin
            sc.last = 1'b1;
            push_o.second = sc;
            push_o.count = 2'd2;
          end else begin
            y = COORD_BITS'(cur_row_i + 1'b1);
          end
          x = '0;
        end else begin
          x = COORD_BITS'(cur_col_i + 1'b1);
        end
        if (push_o.count == 2'd1) begin
          push_o.first.last = 1'b1;
        end
      end
    end

    nxt_col_o = x;
    nxt_row_o = y;
  end

endmodule

`default_nettype wire

### rtl/core/twce_out_fifo.sv
// Four-entry result queue: takes up to two words a cycle, gives one.
// Depends on twce_pkg and the assertion macro header.
`default_nettype none

module twce_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_en_i,
  input  twce_pkg::twce_push_t push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output twce_pkg::twce_out_t  word_o
);
  import twce_pkg::*;

  twce_out_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic [FIFO_PTR_W-1:0]   wr_ptr_nxt;
  logic [1:0]              push_n;
  logic                    pop;

  assign push_n     = push_en_i ? push_i.count : 2'd0;
  assign pop        = valid_o && ready_i;
  assign valid_o    = (count_q != '0);
  assign word_o     = mem_q[rd_ptr_q];
  // Room for the worst case of two words.
  assign room_o     = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_nxt = wr_ptr_q + FIFO_PTR_W'(1);
  assign wr_ptr_d   = wr_ptr_q + FIFO_PTR_W'(push_n);
  assign rd_ptr_d   = rd_ptr_q + FIFO_PTR_W'(pop);
  assign count_d    = count_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

  `include "text_window_cursor_engine_assert.svh"

  `TWCE_ASSERT(a_fifo_bound, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
  `TWCE_ASSERT_IMPL(a_fifo_push_room, push_n != 2'd0, room_o, "push without room")
  `TWCE_ASSERT_NEXT(a_fifo_pop_only, pop && push_n == 2'd0,
                    count_q == $past(count_q) - FIFO_CNT_W'(1), "pop did not drain")

endmodule

`default_nettype wire

### rtl/core/text_window_cursor_engine.sv
// Accepted words go to the input register, and their results to the result queue.
// Throughput: one word per cycle while each word gives at most one result and the
// result side takes one word per cycle; the four-entry result queue sets the pace.
// A word that causes a write and a scroll gives two result words on the result port.
// Reset (asynchronous, active low): cursor at 0,0, window 80x25, attribute 7, queue empty.
`default_nettype none

module text_window_cursor_engine #(
  parameter int COORD_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  twce_stream_if.sink                        in_i,
  twce_stream_if.source                      out_o,
  input  logic                               cfg_we_i,
  input  logic [twce_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [twce_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import twce_pkg::*;

  logic [7:0]            cols_q, rows_q, attr_q;
  logic [COORD_BITS-1:0] col_q, row_q;
  logic [COORD_BITS-1:0] col_d, row_d;
  logic                  s1_valid_q;
  twce_in_t              s1_q;
  twce_push_t            push;
  logic                  room;
  logic                  advance;
  logic                  take;

  assign advance    = s1_valid_q && room;
  assign in_i.ready = !s1_valid_q || advance;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= RESET_COLUMNS;
      rows_q <= RESET_ROWS;
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COLUMNS: cols_q <= cfg_data_i;
        REG_ROWS:    rows_q <= cfg_data_i;
        REG_ATTR:    attr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: hold while the queue lacks room.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= in_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  twce_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .item_i    (s1_q),
    .cur_col_i (col_q),
    .cur_row_i (row_q),
    .cols_i    (cols_q),
    .rows_i    (rows_q),
    .attr_i    (attr_q),
    .push_o    (push),
    .nxt_col_o (col_d),
    .nxt_row_o (row_d)
  );

  twce_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (advance),
    .push_i    (push),
    .room_o    (room),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .word_o    (out_o.payload)
  );

  `include "text_window_cursor_engine_assert.svh"

  `TWCE_ASSERT_NEXT(a_hold_stalled, s1_valid_q && !advance, s1_valid_q,
                    "stalled word lost")
  `TWCE_ASSERT_NEXT(a_cursor_quiet, !advance, $stable(col_q) && $stable(row_q),
                    "cursor moved without a word")
  `TWCE_ASSERT_IMPL(a_pair_last, advance && push.count == 2'd2,
                    push.second.last && !push.first.last, "last flag misplaced")

endmodule

`default_nettype wire

### sim/text_window_cursor_engine_test.sv
`timescale 1ns / 1ps
// Self-checking bench for text_window_cursor_engine: drives character and cursor words,
// predicts cell writes, scrolls and status, and checks every result word in order.
// Depends on twce_pkg and twce_stream_if from the RTL.

module text_window_cursor_engine_test;
  import twce_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  logic clk_i;
  logic rst_ni;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  twce_stream_if #(.payload_t(twce_in_t))  word_in ();
  twce_stream_if #(.payload_t(twce_out_t)) result_out ();

  text_window_cursor_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (word_in),
    .out_o       (result_out),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Window settings as last written, and the predicted cursor.
  logic [7:0] win_cols, win_rows, win_attr;
  logic [7:0] cur_col, cur_row;

  twce_in_t  pending_words[$];
  twce_out_t due_results[$];

  int unsigned tx_gap, rx_gap, rx_pick;
  logic        tx_idle_on, rx_idle_on, rx_hold;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic twce_out_t cell_result(kind_e k, logic [7:0] col, logic [7:0] row,
                                            logic [15:0] cw, logic st);
    twce_out_t r;
    r.kind        = k;
    r.cell_column = col;
    r.cell_row    = row;
    r.cell_word   = cw;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

  // Advance the predicted cursor by one word and queue the results it causes.
  function automatic void cursor_step(twce_in_t w);
    logic [7:0]  last_col, last_row, x, y;
    logic [15:0] cw;
    logic        bad;
    twce_out_t   res[$];
    last_col = ((win_cols == 8'd0) ? 8'd1 : win_cols) - 8'd1;
    last_row = ((win_rows == 8'd0) ? 8'd1 : win_rows) - 8'd1;
    cw = {win_attr, w.char_code};
    x = cur_col;
    y = cur_row;
    if (w.operation == OP_SET_POS) begin
      bad = (w.pos_column > last_col) || (w.pos_row > last_row);
      if (!bad) begin
        x = w.pos_column;
        y = w.pos_row;
      end
      res.push_back(cell_result(KIND_STATUS, 8'd0, 8'd0, 16'd0, bad));
    end else if (w.char_code != CH_NUL) begin
      case (w.char_code)
        CH_NEWLINE: begin
          if (y == last_row) res.push_back(cell_result(KIND_SCROLL, 8'd0, 8'd0, 16'd0, 1'b0));
          else y = y + 8'd1;
        end
        CH_RETURN: x = 8'd0;
        CH_BACKSPACE: begin
          if (x != 8'd0) begin
            x = x - 8'd1;
          end else if (y != 8'd0) begin
            y = y - 8'd1;
            x = last_col;
          end
          res.push_back(cell_result(KIND_WRITE, x, y, cw, 1'b0));
        end
        default: begin
          res.push_back(cell_result(KIND_WRITE, x, y, cw, 1'b0));
          if (x == last_col) begin
            if (y == last_row) res.push_back(cell_result(KIND_SCROLL, 8'd0, 8'd0, 16'd0, 1'b0));
            else y = y + 8'd1;
            x = 8'd0;
          end else begin
            x = x + 8'd1;
          end
        end
      endcase
    end
    cur_col = x;
    cur_row = y;
    if (res.size() != 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) due_results.push_back(res[i]);
  endfunction

  task automatic check_result(twce_out_t got);
    twce_out_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result kind %0d col %0d row %0d word %04h status %0b last %0b",
                 $time, got.kind, got.cell_column, got.cell_row, got.cell_word,
                 got.status, got.last);
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.cell_column !== want.cell_column ||
          got.cell_row !== want.cell_row || got.cell_word !== want.cell_word ||
          got.status !== want.status || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected kind %0d col %0d row %0d word %04h status %0b last %0b",
                   $time, want.kind, want.cell_column, want.cell_row, want.cell_word,
                   want.status, want.last);
          $display("%0t:      got kind %0d col %0d row %0d word %04h status %0b last %0b",
                   $time, got.kind, got.cell_column, got.cell_row, got.cell_word,
                   got.status, got.last);
        end
      end
    end
  endtask

  // Word driver: predict on acceptance, then offer the next queued word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_in.valid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (word_in.valid && word_in.ready) cursor_step(word_in.payload);
      if (!word_in.valid || word_in.ready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          word_in.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_in.payload <= pending_words.pop_front();
          word_in.valid   <= 1'b1;
          tx_gap          <= tx_idle_on ? pick_gap() : 0;
        end else begin
          word_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted word, then pick the next ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_out.ready <= 1'b0;
      rx_gap           <= 0;
    end else begin
      if (result_out.valid && result_out.ready) check_result(result_out.payload);
      if (rx_hold) begin
        result_out.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap           <= rx_gap - 1;
        result_out.ready <= 1'b0;
      end else if (result_out.valid && result_out.ready && rx_idle_on) begin
        rx_pick = pick_gap();
        result_out.ready <= (rx_pick == 0);
        rx_gap           <= (rx_pick == 0) ? 0 : rx_pick - 1;
      end else begin
        result_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((word_in.valid && word_in.ready) || (result_out.valid && result_out.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** text_window_cursor_engine: FAILED **");
      $finish;
    end
  end

  function automatic twce_in_t put_char(logic [7:0] code);
    twce_in_t w;
    w.operation  = OP_PUT_CHAR;
    w.char_code  = code;
    w.pos_column = 8'd0;
    w.pos_row    = 8'd0;
    return w;
  endfunction

  function automatic twce_in_t set_pos(logic [7:0] col, logic [7:0] row);
    twce_in_t w;
    w.operation  = OP_SET_POS;
    w.char_code  = 8'd0;
    w.pos_column = col;
    w.pos_row    = row;
    return w;
  endfunction

  // Mostly text with control codes; position requests aim in, at and past the border.
  function automatic twce_in_t random_word(bit allow_set);
    twce_in_t    w;
    int unsigned r, cols, rows;
    cols = (win_cols == 8'd0) ? 1 : 32'(win_cols);
    rows = (win_rows == 8'd0) ? 1 : 32'(win_rows);
    w.operation  = OP_PUT_CHAR;
    w.char_code  = 8'($urandom_range(0, 255));
    w.pos_column = 8'($urandom_range(0, 255));
    w.pos_row    = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (allow_set && r < 15) begin
      w.operation = OP_SET_POS;
      case ($urandom_range(0, 3))
        0, 1: begin
          w.pos_column = 8'($urandom_range(0, cols - 1));
          w.pos_row    = 8'($urandom_range(0, rows - 1));
        end
        2: begin
          w.pos_column = 8'(cols - 1 + $urandom_range(0, 1));
          w.pos_row    = 8'(rows - 1 + $urandom_range(0, 1));
        end
        default: ;
      endcase
    end else if (r < 30) begin
      w.char_code = CH_NEWLINE;
    end else if (r < 37) begin
      w.char_code = CH_RETURN;
    end else if (r < 47) begin
      w.char_code = CH_BACKSPACE;
    end else if (r < 50) begin
      w.char_code = CH_NUL;
    end else begin
      w.char_code = 8'($urandom_range(1, 255));
    end
    return w;
  endfunction

  task automatic add_random(int unsigned n, bit allow_set);
    repeat (n) pending_words.push_back(random_word(allow_set));
  endtask

  // Wait for the queue and the block to go quiet; words with no result need the tail.
  task automatic settle();
    while (pending_words.size() != 0 || word_in.valid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_COLUMNS: win_cols = val;
      REG_ROWS:    win_rows = val;
      default:     win_attr = val;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(logic [7:0] cols, logic [7:0] rows, logic [7:0] attr);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_ATTR, attr);
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_COLUMNS;
    cfg_data           = '0;
    word_in.valid      = 1'b0;
    word_in.payload    = '0;
    result_out.ready   = 1'b0;
    rx_hold            = 1'b0;
    tx_idle_on         = 1'b1;
    rx_idle_on         = 1'b1;
    mismatches         = 0;
    quiet_cycles       = 0;
    win_cols           = RESET_COLUMNS;
    win_rows           = RESET_ROWS;
    win_attr           = RESET_ATTR;
    cur_col            = 8'd0;
    cur_row            = 8'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: window borders, bad positions, wraps and scrolls on the reset window.
    pending_words.push_back(set_pos(8'd0, 8'd0));
    pending_words.push_back(set_pos(8'd79, 8'd24));
    pending_words.push_back(put_char(8'h41));          // bottom-right: write then scroll
    pending_words.push_back(put_char(CH_BACKSPACE));   // wrap back to previous row end
    pending_words.push_back(set_pos(8'd80, 8'd0));
    pending_words.push_back(set_pos(8'd0, 8'd25));
    pending_words.push_back(set_pos(8'd255, 8'd255));
    pending_words.push_back(set_pos(8'd0, 8'd0));
    pending_words.push_back(put_char(CH_BACKSPACE));   // top-left: stay and write
    pending_words.push_back(put_char(CH_NUL));
    pending_words.push_back(put_char(CH_NEWLINE));
    pending_words.push_back(put_char(CH_RETURN));
    pending_words.push_back(put_char(8'hFF));
    pending_words.push_back(set_pos(8'd3, 8'd24));
    pending_words.push_back(put_char(CH_NEWLINE));     // bottom row: scroll only
    pending_words.push_back(put_char(8'h7F));
    pending_words.push_back(set_pos(8'd79, 8'd10));
    pending_words.push_back(put_char(8'h20));
    settle();

    set_window(8'd1, 8'd1, 8'hFF);
    add_random(150, 1'b1);
    settle();

    // Zero sizes act as a single cell.
    set_window(8'd0, 8'd0, 8'h00);
    add_random(150, 1'b1);
    settle();

    tx_idle_on <= 1'b0;
    rx_idle_on <= 1'b0;
    set_window(8'd255, 8'd255, 8'hA5);
    add_random(200, 1'b1);
    pending_words.push_back(set_pos(8'd200, 8'd200));
    settle();

    // Shrink under the cursor: it runs on and wraps past 255.
    tx_idle_on <= 1'b1;
    rx_idle_on <= 1'b1;
    set_window(8'd10, 8'd5, 8'h5A);
    add_random(120, 1'b0);
    settle();

    // Hold the result side while words keep coming, so the input stalls.
    set_window(8'd4, 8'd3, 8'($urandom_range(0, 255)));
    @(posedge clk_i);
    rx_hold <= 1'b1;
    add_random(80, 1'b1);
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 2)
        set_window(8'($urandom_range(100, 255)), 8'($urandom_range(1, 4)),
                   8'($urandom_range(0, 255)));
      else
        set_window(8'($urandom_range(1, 24)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(0, 255)));
      add_random(180, 1'b1);
      settle();
    end

    if (mismatches == 0 && due_results.size() == 0)
      $display("** text_window_cursor_engine: PASSED **");
    else
      $display("** text_window_cursor_engine: FAILED **");
    $finish;
  end

endmodule

### text_window_cursor_engine.f
+incdir+rtl/core
rtl/core/twce_pkg.sv
rtl/core/twce_stream_if.sv
rtl/core/twce_step.sv
rtl/core/twce_out_fifo.sv
rtl/core/text_window_cursor_engine.sv
sim/text_window_cursor_engine_test.sv
